[rtl/sha384_pkg.sv]
// SHA-384 package: round constants, initial hash values, sigma functions.
// No dependencies.
`timescale 1ns / 1ps
package sha384_pkg;

	localparam int ROUND_COUNT = 80;
	localparam int RND_W = $clog2(ROUND_COUNT + 1);

	localparam logic [63:0] START_H [8] = '{
		64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
		64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
	};

	localparam logic [63:0] ROUND_K [80] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};

	function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
		rotr = (x >> n) | (x << (64 - n));
	endfunction

	function automatic logic [63:0] sig0(input logic [63:0] x);
		sig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
	endfunction

	function automatic logic [63:0] sig1(input logic [63:0] x);
		sig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
	endfunction

	function automatic logic [63:0] bsig0(input logic [63:0] x);
		bsig0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
	endfunction

	function automatic logic [63:0] bsig1(input logic [63:0] x);
		bsig1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
	endfunction

endpackage

[rtl/sha384_round.sv]
// SHA-384 shared round unit: one compression round plus schedule word update.
// Depends on sha384_pkg.
`timescale 1ns / 1ps
module sha384_round import sha384_pkg::*; (
	input  logic [63:0] v_in [8],
	input  logic [63:0] w_m16,
	input  logic [63:0] w_m15,
	input  logic [63:0] w_m7,
	input  logic [63:0] w_m2,
	input  logic        expand,
	input  logic [63:0] k_in,
	output logic [63:0] w_out,
	output logic [63:0] v_out [8]
);
	logic [63:0] t1, t2, ch, mj;

	always_comb begin
		w_out = expand ? (w_m16 + sig0(w_m15) + w_m7 + sig1(w_m2)) : w_m16;
		ch = (v_in[4] & v_in[5]) ^ (~v_in[4] & v_in[6]);
		mj = (v_in[0] & v_in[1]) ^ (v_in[0] & v_in[2]) ^ (v_in[1] & v_in[2]);
		t1 = v_in[7] + bsig1(v_in[4]) + ch + k_in + w_out;
		t2 = bsig0(v_in[0]) + mj;
		v_out[7] = v_in[6];
		v_out[6] = v_in[5];
		v_out[5] = v_in[4];
		v_out[4] = v_in[3] + t1;
		v_out[3] = v_in[2];
		v_out[2] = v_in[1];
		v_out[1] = v_in[0];
		v_out[0] = t1 + t2;
	end
endmodule

[rtl/sha384_stream_hasher_core.sv]
// SHA-384 stream hasher top level: padding sequencer, schedule window, chain values.
// Depends on sha384_pkg and sha384_round.
// A word that fills a block starts 80 rounds on the single shared round unit, then
// the chain update (ST_RND, ST_UPD); in_ready is low until they are done. A last
// word also runs padding and length words, then six digest transfers. Reset is
// asynchronous, active low.
`timescale 1ns / 1ps
module sha384_stream_hasher_core import sha384_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] msg_word,
	input  logic [3:0]  byte_count,
	input  logic        last_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] digest_word,
	output logic        digest_last
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PAD  = 3'd1;
	localparam logic [2:0] ST_RND  = 3'd2;
	localparam logic [2:0] ST_UPD  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]       state_q;
	logic [63:0]      h_q [8];
	logic [63:0]      v_q [8];
	logic [63:0]      w_q [16];
	logic [63:0]      bytes_q;
	logic [3:0]       slot_q;
	logic [RND_W-1:0] rnd_q;
	logic             fin_q;      // padding pending after current block
	// 0: none, 1: pad byte word due, 2: zero/length fill,
	// 3: zero fill only, length goes in the next block
	logic [1:0]       pad_q;
	logic [2:0]       oidx_q;

	logic [63:0] w_new;
	logic [63:0] v_new [8];
	logic [3:0]  ti;
	logic [63:0] pad_word;
	logic [3:0]  cnt;

	assign ti = rnd_q[3:0];

	sha384_round u_round (
		.v_in(v_q),
		.w_m16(w_q[ti]),
		.w_m15(w_q[ti + 4'd1]),
		.w_m7(w_q[ti + 4'd9]),
		.w_m2(w_q[ti + 4'd14]),
		.expand(rnd_q >= RND_W'(16)),
		.k_in(ROUND_K[rnd_q]),
		.w_out(w_new),
		.v_out(v_new)
	);

	// Masked last word, with pad byte when it holds fewer than eight bytes
	always_comb begin
		cnt = (byte_count > 4'd8) ? 4'd8 : byte_count;
		pad_word = msg_word & ~(64'hffff_ffff_ffff_ffff >> (8 * cnt));
		if (cnt != 4'd8) pad_word = pad_word | (64'h80 << (56 - 8 * cnt));
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = (state_q == ST_OUT);
	assign digest_word = h_q[oidx_q];
	assign digest_last = (oidx_q == 3'd5);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bytes_q <= '0;
			slot_q  <= '0;
			rnd_q   <= '0;
			fin_q   <= 1'b0;
			pad_q   <= '0;
			oidx_q  <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= START_H[i];
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (!last_word) begin
							w_q[slot_q] <= msg_word;
							bytes_q <= bytes_q + 64'd8;
						end else begin
							w_q[slot_q] <= pad_word;
							bytes_q <= bytes_q + 64'(cnt);
							fin_q <= 1'b1;
							if (cnt == 4'd8) pad_q <= 2'd1;
							else pad_q <= (slot_q >= 4'd14) ? 2'd3 : 2'd2;
						end
						slot_q <= slot_q + 4'd1;
						if (slot_q == 4'd15) begin
							state_q <= ST_RND;
							for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
						end else if (last_word) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					// one padding word per cycle
					if (pad_q == 2'd1) begin
						w_q[slot_q] <= 64'h8000_0000_0000_0000;
						pad_q <= (slot_q >= 4'd14) ? 2'd3 : 2'd2;
					end else if (slot_q == 4'd15 && pad_q == 2'd2) begin
						w_q[slot_q] <= bytes_q << 3;
						fin_q <= 1'b0;
					end else begin
						w_q[slot_q] <= 64'd0;
					end
					slot_q <= slot_q + 4'd1;
					if (slot_q == 4'd15) begin
						state_q <= ST_RND;
						for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
					end
				end
				ST_RND: begin
					w_q[ti] <= w_new;
					for (int i = 0; i < 8; i++) v_q[i] <= v_new[i];
					if (rnd_q == RND_W'(ROUND_COUNT - 1)) begin
						rnd_q <= '0;
						state_q <= ST_UPD;
					end else begin
						rnd_q <= rnd_q + RND_W'(1);
					end
				end
				ST_UPD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					// pad byte in slot 14 or 15 leaves no room: length goes in one more block
					if (fin_q) begin
						state_q <= ST_PAD;
						if (pad_q == 2'd3) pad_q <= 2'd2;
					end else if (pad_q != 2'd0) begin
						state_q <= ST_OUT;
						oidx_q <= '0;
					end else state_q <= ST_IDLE;
				end
				ST_OUT: begin
					if (out_ready) begin
						if (oidx_q == 3'd5) begin
							state_q <= ST_IDLE;
							pad_q <= '0;
							bytes_q <= '0;
							slot_q <= '0;
							for (int i = 0; i < 8; i++) h_q[i] <= START_H[i];
						end
						oidx_q <= oidx_q + 3'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[rtl/sha384_chk.sv]
// Port-level checker for the SHA-384 hasher, bound to the top level.
// Depends on sha384_stream_hasher_core ports only.
`timescale 1ns / 1ps
module sha384_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] digest_word,
	input logic        digest_last
);
	// never take input while a digest is pending
	a_excl: assert property (@(posedge clk) disable iff (!arst_n) !(in_ready && out_valid))
		else $error("input ready while digest pending");
	// stalled digest holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digest_word) && $stable(digest_last))
		else $error("digest changed under stall");
	// after final digest transfer, no output the next cycle
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && digest_last |=> !out_valid)
		else $error("output after last digest word");
	// a non-final transfer is followed by more output
	a_more: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !digest_last |=> out_valid)
		else $error("digest sequence broken");
endmodule

bind sha384_stream_hasher_core sha384_chk u_chk (.*);

[dv/sha384_stream_hasher_core_test.sv]
// Testbench for sha384_stream_hasher_core: random and directed messages, digest check.
// Depends on sha384_pkg (for the round constants and initial values) and the core RTL.
`timescale 1ns / 1ps

class digest_scoreboard;
	logic [63:0] chain [8];
	logic [63:0] window [16];
	logic [63:0] msg_len;
	int unsigned slot;
	logic [63:0] exp_word [$];
	logic exp_last [$];
	int unsigned errors;

	function new();
		restart();
		errors = 0;
	endfunction

	function void restart();
		for (int i = 0; i < 8; i++) chain[i] = sha384_pkg::START_H[i];
		msg_len = 0;
		slot = 0;
	endfunction

	function logic [63:0] ror(logic [63:0] x, int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	// one 80-round compression of the current window into the chain
	function void compress();
		logic [63:0] v [8];
		logic [63:0] a, b, w, t1, t2;
		for (int i = 0; i < 8; i++) v[i] = chain[i];
		for (int t = 0; t < 80; t++) begin
			if (t >= 16) begin
				a = window[(t + 1) % 16];
				b = window[(t + 14) % 16];
				window[t % 16] = window[t % 16] + (ror(a, 1) ^ ror(a, 8) ^ (a >> 7))
					+ window[(t + 9) % 16] + (ror(b, 19) ^ ror(b, 61) ^ (b >> 6));
			end
			w = window[t % 16];
			t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha384_pkg::ROUND_K[t] + w;
			t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) chain[i] += v[i];
	endfunction

	function void push(logic [63:0] w);
		window[slot] = w;
		slot++;
		if (slot == 16) begin
			slot = 0;
			compress();
		end
	endfunction

	// note one accepted input word
	function void note_word(logic [63:0] word, logic [3:0] cnt_in, logic last);
		int unsigned cnt;
		if (!last) begin
			msg_len += 8;
			push(word);
			return;
		end
		cnt = (cnt_in > 8) ? 8 : cnt_in;
		msg_len += cnt;
		if (cnt < 8) begin
			if (cnt == 0) word = '0;
			else word &= ~64'd0 << (64 - 8 * cnt);
			word |= 64'h80 << (56 - 8 * cnt);
			push(word);
		end else begin
			push(word);
			push(64'h80 << 56);
		end
		while (slot != 14) push('0);
		push('0);
		push(msg_len << 3);
		for (int i = 0; i < 6; i++) begin
			exp_word.push_back(chain[i]);
			exp_last.push_back(i == 5);
		end
		restart();
	endfunction

	// compare one digest transfer with the oldest expectation
	function void check_digest(logic [63:0] word, logic last);
		logic [63:0] ew;
		logic el;
		if (exp_word.size() == 0) begin
			$display("%0t: unexpected digest word %h last %b", $time, word, last);
			errors++;
			return;
		end
		ew = exp_word.pop_front();
		el = exp_last.pop_front();
		if (word !== ew) begin
			$display("%0t: digest_word expected %h actual %h", $time, ew, word);
			errors++;
		end
		if (last !== el) begin
			$display("%0t: digest_last expected %b actual %b", $time, el, last);
			errors++;
		end
	endfunction
endclass

module sha384_stream_hasher_core_test;
	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [63:0] msg_word = '0;
	logic [3:0] byte_count = '0;
	logic last_word = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [63:0] digest_word;
	logic digest_last;

	digest_scoreboard sb;
	int unsigned send_idle = 0;
	int unsigned recv_stall = 0;

	sha384_stream_hasher_core dut (.*);

	always #5 clk = ~clk;

	// receiver: random stall, check each transfer
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_digest(digest_word, digest_last);
		out_ready <= ($urandom_range(99) >= recv_stall);
	end

	// send one word; optional idle cycles first; valid stays up until the next call
	task automatic send_word(logic [63:0] w, logic [3:0] c, logic l);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		msg_word <= w;
		byte_count <= c;
		last_word <= l;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_word(w, c, l);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// random message of n full words then a last word
	task automatic send_message(int n);
		logic [3:0] c;
		for (int i = 0; i < n; i++)
			send_word(rand64(), ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'd8, 0);
		c = ($urandom_range(4) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(8));
		send_word(rand64(), c, 1);
	endtask

	// sender pauses until every expected digest word has come
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (sb.exp_word.size() != 0) @(posedge clk);
	endtask

	initial begin
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty message, each byte count, pad crossing, long/short
		send_word('0, 4'd0, 1);
		for (int c = 0; c <= 15; c++) send_word(rand64(), 4'(c), 1);
		send_word(64'hffff_ffff_ffff_ffff, 4'd8, 0);
		send_word(64'h0, 4'd3, 0);
		send_word(64'hffff_ffff_ffff_ffff, 4'd8, 1);
		for (int i = 0; i < 14; i++) send_word(rand64(), 4'd8, 0);
		send_word(rand64(), 4'd8, 1);
		drain();

		// random phases with different idling
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 64; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 64; end
				default: begin send_idle = 15; recv_stall = 15; end
			endcase
			for (int k = 0; k < 45; ) begin
				int n;
				n = ($urandom_range(5) == 0) ? $urandom_range(14, 33) : $urandom_range(0, 6);
				send_message(n);
				k += n + 1;
				if ($urandom_range(5) == 0) drain();
			end
			drain();
		end
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.exp_word.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end
endmodule

[files.f]
rtl/sha384_pkg.sv
rtl/sha384_round.sv
rtl/sha384_stream_hasher_core.sv
rtl/sha384_chk.sv
dv/sha384_stream_hasher_core_test.sv
